// ===== rtl/keat_pkg.sv =====
// Shared types and constants for the key edge and auto-repeat tracker.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package keat_pkg;

	// Widest key bitmap the block handles.
	localparam int unsigned KEY_MAX = 64;

	// Hold counter and hold delay width.
	localparam int unsigned CNT_W = 16;

	// The repeat interval is the hold delay divided by four.
	localparam int unsigned REPEAT_SHIFT = 2;

	// Configuration port geometry.
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	// Register word indexes.
	localparam logic [APB_ADDR_W-3:0] REG_HOLD_DELAY = 1'b0;

	localparam logic [CNT_W-1:0] HOLD_DELAY_RESET = 16'd20;

	// Result word: five masks and one flag, padded to whole bytes.
	localparam int unsigned RES_BITS = 5 * KEY_MAX + 1;
	localparam int unsigned RES_W    = ((RES_BITS + 7) / 8) * 8;

	typedef logic [CNT_W-1:0] count_t;

	// Per-key flags for one tick.
	typedef struct packed {
		logic pressed;
		logic released;
		logic held;
		logic down;
		logic inactive;
	} key_flags_t;

endpackage

`default_nettype wire

// ===== rtl/key_edge_and_autorepeat_tracker_top.sv =====
// Key edge and auto-repeat tracker. Each input word is one scan tick with one bit per key;
// each tick yields one output word of pressed, released, held, down and inactive masks and
// a flag for exactly one key down. A word goes through an input register and a result
// register, and the block takes a new word every cycle while the output side accepts;
// all keys update in parallel in their own cells. hold_delay is written through the APB port
// at address 0; the user must write it only while no word is in flight, as the block does not enforce it.
// Depends on keat_pkg, keat_apb_regs and keat_key_cell.
`default_nettype none

module key_edge_and_autorepeat_tracker_top #(
	parameter int unsigned NUM_KEYS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// s_tdata: key_states[63:0]
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [keat_pkg::KEY_MAX-1:0]      s_tdata,
	// m_tdata: pressed_mask[63:0], released_mask[127:64], held_mask[191:128],
	// down_mask[255:192], inactive_mask[319:256], only_one_down[320], zeros above
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [keat_pkg::RES_W-1:0]        m_tdata,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [keat_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [keat_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [keat_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready
);

	localparam int unsigned KM = keat_pkg::KEY_MAX;

	keat_pkg::count_t hold_delay;
	keat_pkg::count_t repeat_step;

	logic          valid_s1;
	logic [KM-1:0] keys_s1;
	logic          out_valid_q;
	logic [keat_pkg::RES_W-1:0] out_data_q;
	logic          advance;

	logic [KM-1:0] pressed, released, held, down, inactive;
	logic          only_one;
	logic [keat_pkg::RES_W-1:0] res;

	keat_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.hold_delay (hold_delay)
	);

	assign repeat_step = hold_delay >> keat_pkg::REPEAT_SHIFT;

	// The input stage moves on when the result register is free or being drained.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			keys_s1 <= s_tdata;
		end
	end

	for (genvar i = 0; i < KM; i++) begin : g_key
		if (i < NUM_KEYS) begin : g_cell
			keat_pkg::key_flags_t flags;

			keat_key_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cur         (keys_s1[i]),
				.advance     (advance),
				.hold_delay  (hold_delay),
				.repeat_step (repeat_step),
				.flags       (flags)
			);

			assign pressed[i]  = flags.pressed;
			assign released[i] = flags.released;
			assign held[i]     = flags.held;
			assign down[i]     = flags.down;
			assign inactive[i] = flags.inactive;
		end else begin : g_none
			assign pressed[i]  = 1'b0;
			assign released[i] = 1'b0;
			assign held[i]     = 1'b0;
			assign down[i]     = 1'b0;
			assign inactive[i] = 1'b0;
		end
	end

	// Exactly one bit set: nonzero, and clearing the lowest set bit leaves nothing.
	assign only_one = (down != '0) && ((down & (down - KM'(1))) == '0);

	always_comb begin
		res = '0;
		res[0*KM +: KM] = pressed;
		res[1*KM +: KM] = released;
		res[2*KM +: KM] = held;
		res[3*KM +: KM] = down;
		res[4*KM +: KM] = inactive;
		res[5*KM]       = only_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/keat_apb_regs.sv =====
// APB configuration register file: holds the hold delay.
// Depends on keat_pkg.
`default_nettype none

module keat_apb_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [keat_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [keat_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [keat_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output keat_pkg::count_t                       hold_delay
);

	keat_pkg::count_t hold_delay_q;
	logic             sel_hold;

	assign pready   = 1'b1;
	assign sel_hold = (paddr[keat_pkg::APB_ADDR_W-1:2] == keat_pkg::REG_HOLD_DELAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_delay_q <= keat_pkg::HOLD_DELAY_RESET;
		end else if (psel && penable && pwrite && pready && sel_hold) begin
			hold_delay_q <= pwdata[keat_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_hold) begin
			prdata[keat_pkg::CNT_W-1:0] = hold_delay_q;
		end
	end

	assign hold_delay = hold_delay_q;

endmodule

`default_nettype wire

// ===== rtl/keat_key_cell.sv =====
// One key: previous state, hold counter and the flags of the current tick.
// Depends on keat_pkg.
`default_nettype none

module keat_key_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cur,
	input  wire logic                 advance,
	input  wire keat_pkg::count_t     hold_delay,
	input  wire keat_pkg::count_t     repeat_step,
	output keat_pkg::key_flags_t      flags
);

	logic             down_last_q;
	keat_pkg::count_t hold_count_q;
	keat_pkg::count_t base;
	keat_pkg::count_t count_next;

	// A counter sitting at the delay is pulled back by a quarter before counting on.
	always_comb begin
		base = (hold_count_q == hold_delay) ? hold_count_q - repeat_step : hold_count_q;
		if (!cur) begin
			count_next = '0;
		end else if (down_last_q) begin
			count_next = base + keat_pkg::count_t'(1);
		end else begin
			count_next = hold_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_last_q  <= 1'b0;
			hold_count_q <= '0;
		end else if (advance) begin
			down_last_q  <= cur;
			hold_count_q <= count_next;
		end
	end

	assign flags.pressed  = cur & ~down_last_q;
	assign flags.released = ~cur & down_last_q;
	assign flags.inactive = ~cur & ~down_last_q;
	assign flags.down     = cur;
	assign flags.held     = (count_next == hold_delay);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the key edge and auto-repeat tracker: directed and random scan ticks,
// per-key prediction of the five masks and the one-key flag, with hold_delay written over APB.
// Depends on keat_pkg and key_edge_and_autorepeat_tracker_top.
`default_nettype none

typedef struct packed {
	logic [63:0] pressed;
	logic [63:0] released;
	logic [63:0] held;
	logic [63:0] down;
	logic [63:0] inactive;
	logic        one_down;
} tick_masks_t;

class key_mask_checker;
	int              nkeys;
	bit [63:0]       key_prev;
	keat_pkg::count_t hold_cnt[64];
	keat_pkg::count_t delay_q;
	tick_masks_t     pending_masks[$];
	int              errors;

	function new(int n);
		nkeys = n;
		key_prev = '0;
		foreach (hold_cnt[k]) hold_cnt[k] = '0;
		delay_q = keat_pkg::HOLD_DELAY_RESET;
		errors = 0;
	endfunction

	function void set_delay(keat_pkg::count_t val);
		delay_q = val;
	endfunction

	function int pending();
		return pending_masks.size();
	endfunction

	// Advances every key by one scan tick and queues the masks that tick should produce.
	function void note_tick(logic [63:0] keys);
		tick_masks_t      m;
		int               ndown;
		bit               cur;
		bit               prev;
		keat_pkg::count_t h;
		m = '0;
		ndown = 0;
		for (int k = 0; k < nkeys; k++) begin
			cur = keys[k];
			prev = key_prev[k];
			if (cur) begin
				if (prev) begin
					h = hold_cnt[k];
					if (h == delay_q)
						h = h - (delay_q >> keat_pkg::REPEAT_SHIFT);
					hold_cnt[k] = h + 16'd1;
				end
			end else begin
				hold_cnt[k] = '0;
			end
			key_prev[k] = cur;
			m.pressed[k] = cur && !prev;
			m.released[k] = !cur && prev;
			m.inactive[k] = !cur && !prev;
			m.down[k] = cur;
			m.held[k] = (hold_cnt[k] == delay_q);
			if (cur) ndown++;
		end
		m.one_down = (ndown == 1);
		pending_masks.push_back(m);
	endfunction

	function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
		if (act !== exp) begin
			$error("%s: expected %h, got %h", name, exp, act);
			errors++;
		end
	endfunction

	function void check_masks(logic [keat_pkg::RES_W-1:0] word);
		tick_masks_t e;
		if (pending_masks.size() == 0) begin
			$error("unexpected result word %h", word);
			errors++;
			return;
		end
		e = pending_masks.pop_front();
		compare_field("pressed_mask", e.pressed, word[0 +: 64]);
		compare_field("released_mask", e.released, word[64 +: 64]);
		compare_field("held_mask", e.held, word[128 +: 64]);
		compare_field("down_mask", e.down, word[192 +: 64]);
		compare_field("inactive_mask", e.inactive, word[256 +: 64]);
		compare_field("only_one_down", {63'd0, e.one_down}, {63'd0, word[320]});
	endfunction
endclass

module testbench;
	localparam int unsigned NUM_KEYS = 64;
	localparam logic [keat_pkg::APB_ADDR_W-1:0] HOLD_ADDR = {keat_pkg::REG_HOLD_DELAY, 2'b00};
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 220;
	localparam int LONG_STALL = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [keat_pkg::KEY_MAX-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [keat_pkg::RES_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [keat_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [keat_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [keat_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	bit calm = 1'b0;
	bit stall_req = 1'b0;
	bit stall_done = 1'b0;
	int stall_cycles = 0;

	key_mask_checker masks = new(NUM_KEYS);

	key_edge_and_autorepeat_tracker_top #(.NUM_KEYS(NUM_KEYS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver stalls at random, except in the calm stretch and during the one long hold-off.
	always @(negedge clk) begin
		if (stall_req && !stall_done) begin
			m_tready <= 1'b0;
			stall_cycles++;
			if (stall_cycles >= LONG_STALL) stall_done = 1'b1;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 18);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) masks.check_masks(m_tdata);
	end

	task automatic send_tick(input logic [63:0] keys);
		if (!calm && $urandom_range(99) < 18) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= keys;
		do @(posedge clk); while (!s_tready);
		masks.note_tick(keys);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (masks.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes hold_delay and reads it back.
	task automatic program_delay(input keat_pkg::count_t val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= HOLD_ADDR;
		pwdata <= {16'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		masks.set_delay(val);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== val) begin
			$error("hold_delay readback: expected %h, got %h", val, prdata[15:0]);
			masks.errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [63:0] directed[];
		keat_pkg::count_t delays[PHASES];
		logic [63:0] keys;
		int mode;

		directed = '{64'd0, '1, '1, '1, '1, '1, '1, '1, '1, 64'd0,
			64'h1, 64'h1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
			64'd0, '1, 64'd0};
		delays = '{16'd1, 16'd2, 16'd3, 16'd20, 16'd5,
			16'd8, 16'd65535, 16'd6, 16'd13};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Short repeat interval so the directed holds show the first pulse and several repeats.
		program_delay(16'd4);
		foreach (directed[i]) send_tick(directed[i]);
		drain();

		keys = '0;
		for (int p = 0; p < PHASES; p++) begin
			program_delay(delays[p]);
			calm = (p == 4);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 1 && i == 60) stall_req = 1'b1;
				if (p == 2 && i == 100) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
					while (masks.pending() != 0) @(posedge clk);
				end
				// Mostly slow drift of the bitmap so keys stay down long enough to repeat.
				mode = $urandom_range(99);
				if (mode < 70) begin
					repeat ($urandom_range(2)) keys[$urandom_range(63)] ^= 1'b1;
				end else if (mode < 78) begin
					keys = 64'd1 << $urandom_range(63);
				end else if (mode < 88) begin
					keys = keys;
				end else if (mode < 95) begin
					keys = {$urandom, $urandom};
				end else begin
					keys = ($urandom_range(1) != 0) ? '1 : '0;
				end
				send_tick(keys);
			end
			drain();
		end
		calm = 1'b0;

		repeat (8) @(posedge clk);
		if (masks.errors == 0 && masks.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/keat_pkg.sv
rtl/keat_apb_regs.sv
rtl/keat_key_cell.sv
rtl/key_edge_and_autorepeat_tracker_top.sv
tb/testbench.sv
